FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared sizes, action and status codes, entry types and helpers of the
// key sequence matcher.
// ----------------------------------------------------------------------------
package ksm_pkg;

	localparam int MAX_KEYS       = 4;
	localparam int TABLE_ENTRIES  = 128;
	localparam int FUNCTION_COUNT = 128;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int KEY_W  = 32;
	localparam int LEN_W  = 3;
	localparam int FUNC_W = 7;
	localparam int ACT_W  = 2;
	localparam int ST_W   = 3;
	localparam int BYTE_W = 8;

	localparam logic [ACT_W-1:0] ACT_KEY    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BIND   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

	localparam logic [ST_W-1:0] ST_PENDING  = 3'd0;
	localparam logic [ST_W-1:0] ST_MATCHED  = 3'd1;
	localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd2;
	localparam logic [ST_W-1:0] ST_BOUND    = 3'd3;
	localparam logic [ST_W-1:0] ST_REMOVED  = 3'd4;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd6;
	localparam logic [ST_W-1:0] ST_CLEARED  = 3'd7;

	// one stored binding; the valid bit lives in flip-flops beside the memory
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [KEY_W-1:0]  keys;
		logic [FUNC_W-1:0] func;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic exact;
		logic prefix;
	} match_t;

	// keep the low n bytes of a key word
	function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int b = 0; b < MAX_KEYS; b++) begin
			if (LEN_W'(b) < n) begin
				m[b*BYTE_W +: BYTE_W] = '1;
			end
		end
		return m;
	endfunction

	// zero counts as one, anything above MAX_KEYS as MAX_KEYS
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
		logic [LEN_W-1:0] l;
		l = raw;
		if (l == '0) begin
			l = LEN_W'(1);
		end
		if (l > LEN_W'(MAX_KEYS)) begin
			l = LEN_W'(MAX_KEYS);
		end
		return l;
	endfunction

endpackage

FILE: sv/ksm_ram.sv
// ----------------------------------------------------------------------------
// ksm_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module ksm_ram #(
	parameter int ADDR_W = 7,
	parameter int DATA_W = 42
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/ksm_match.sv
// ----------------------------------------------------------------------------
// ksm_match
// Compares one table entry against a query sequence: exact equality and
// proper-prefix test.
// ----------------------------------------------------------------------------
module ksm_match (
	input  logic                         entry_valid,
	input  ksm_pkg::entry_t              entry,
	input  logic [ksm_pkg::KEY_W-1:0]    query_keys,
	input  logic [ksm_pkg::LEN_W-1:0]    query_len,
	output ksm_pkg::match_t              result
);

	import ksm_pkg::*;

	logic [KEY_W-1:0] masked_keys;

	assign masked_keys = entry.keys & byte_mask(query_len);

	always_comb begin
		result.exact  = entry_valid && (entry.len == query_len) && (entry.keys == query_keys);
		result.prefix = entry_valid && (entry.len > query_len) && (masked_keys == query_keys);
	end

endmodule

FILE: sv/key_sequence_matcher.sv
// ----------------------------------------------------------------------------
// key_sequence_matcher
// Table of key sequences bound to function numbers, matched against a
// stream of keystrokes.
// ----------------------------------------------------------------------------
// Usage:
//   Present a transaction on action and its payload fields with start high;
//   it is taken at a rising edge where start is high and busy is low.
//   Key byte, bind and remove scan the whole binding memory, one entry per
//   cycle through a registered read and a single compare unit, then decide
//   and write back in a finish cycle. The result appears on status,
//   matched_function and sequence_length with done high for one cycle,
//   registered from the finish state.
//   Clear-all drops every valid bit at once and reports the next cycle.
//   Busy is low in the cycle that done is high, so a new transaction may be
//   taken there; no new transaction is taken while a scan is under way.
//   The receiver cannot stall: each result is shown for exactly one cycle.
//   Reset empties the table (valid flip-flops cleared) and the pending
//   sequence; no clearing pass over the memory is needed.
// ----------------------------------------------------------------------------
module key_sequence_matcher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ksm_pkg::ACT_W-1:0]    action,
	input  logic [ksm_pkg::BYTE_W-1:0]   key_byte,
	input  logic [ksm_pkg::KEY_W-1:0]    entry_key_bytes,
	input  logic [ksm_pkg::LEN_W-1:0]    entry_key_length,
	input  logic [ksm_pkg::FUNC_W-1:0]   entry_function,
	output logic                         done,
	output logic [ksm_pkg::ST_W-1:0]     status,
	output logic [ksm_pkg::FUNC_W-1:0]   matched_function,
	output logic [ksm_pkg::LEN_W-1:0]    sequence_length
);

	import ksm_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [1:0]               state_q;
	logic [IDX_W-1:0]         rd_addr_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]         pending_bytes_q;
	logic [LEN_W-1:0]         pending_count_q;
	logic                     done_q;

	logic [ACT_W-1:0]  q_action_q;
	logic [KEY_W-1:0]  q_keys_q;
	logic [LEN_W-1:0]  q_len_q;
	logic [FUNC_W-1:0] q_func_q;

	logic             cmp_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             valid_s1;

	logic              exact_found_q;
	logic [IDX_W-1:0]  exact_idx_q;
	logic [FUNC_W-1:0] exact_func_q;
	logic              prefix_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic [ST_W-1:0]   status_q;
	logic [FUNC_W-1:0] func_q;
	logic [LEN_W-1:0]  len_q;

	logic             accept;
	logic [KEY_W-1:0] base_bytes;
	logic [LEN_W-1:0] base_cnt;
	logic [KEY_W-1:0] new_bytes;
	logic [LEN_W-1:0] new_cnt;
	logic [LEN_W-1:0] eq_len;
	logic [KEY_W-1:0] eq_keys;

	entry_t   rd_entry;
	entry_t   wr_entry;
	match_t   cmp;

	logic [ST_W-1:0]   fin_status;
	logic [FUNC_W-1:0] fin_func;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic              clr_valid;
	logic              keep_pending;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// next pending sequence: restart when full, then append into the next lane
	always_comb begin
		base_bytes = (pending_count_q >= LEN_W'(MAX_KEYS)) ? '0 : pending_bytes_q;
		base_cnt   = (pending_count_q >= LEN_W'(MAX_KEYS)) ? '0 : pending_count_q;
		new_bytes  = base_bytes;
		for (int b = 0; b < MAX_KEYS; b++) begin
			if (base_cnt == LEN_W'(b)) begin
				new_bytes[b*BYTE_W +: BYTE_W] = base_bytes[b*BYTE_W +: BYTE_W] | key_byte;
			end
		end
		new_cnt = base_cnt + LEN_W'(1);
	end

	assign eq_len  = clamp_len(entry_key_length);
	assign eq_keys = entry_key_bytes & byte_mask(eq_len);

	assign wr_entry.len  = q_len_q;
	assign wr_entry.keys = q_keys_q;
	assign wr_entry.func = q_func_q;

	ksm_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.raddr (rd_addr_q),
		.rdata (rd_entry)
	);

	ksm_match u_match (
		.entry_valid (valid_s1),
		.entry       (rd_entry),
		.query_keys  (q_keys_q),
		.query_len   (q_len_q),
		.result      (cmp)
	);

	// decision after the scan; the memory is written only here, valid bits here and by clear-all
	always_comb begin
		fin_status   = ST_UNKNOWN;
		fin_func     = '0;
		wr_en        = 1'b0;
		wr_idx       = exact_idx_q;
		clr_valid    = 1'b0;
		keep_pending = 1'b0;
		case (q_action_q)
			ACT_KEY: begin
				if (exact_found_q) begin
					fin_status = ST_MATCHED;
					fin_func   = exact_func_q;
				end else if (prefix_q) begin
					fin_status   = ST_PENDING;
					keep_pending = 1'b1;
				end else begin
					fin_status = ST_UNKNOWN;
				end
			end
			ACT_BIND: begin
				if (int'(q_func_q) >= FUNCTION_COUNT) begin
					fin_status = ST_NOTFOUND;
				end else if (exact_found_q) begin
					fin_status = ST_BOUND;
					wr_en      = (state_q == S_FINISH);
				end else if (free_found_q) begin
					fin_status = ST_BOUND;
					wr_idx     = free_idx_q;
					wr_en      = (state_q == S_FINISH);
				end else begin
					fin_status = ST_FULL;
				end
			end
			ACT_REMOVE: begin
				if (exact_found_q) begin
					fin_status = ST_REMOVED;
					clr_valid  = (state_q == S_FINISH);
				end else begin
					fin_status = ST_NOTFOUND;
				end
			end
			default: begin
				fin_status = ST_CLEARED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			rd_addr_q       <= '0;
			valid_q         <= '0;
			pending_bytes_q <= '0;
			pending_count_q <= '0;
			done_q          <= 1'b0;
			cmp_vld_s1      <= 1'b0;
			exact_found_q   <= 1'b0;
			prefix_q        <= 1'b0;
			free_found_q    <= 1'b0;
		end else begin
			done_q     <= (state_q == S_FINISH) || (accept && action == ACT_CLEAR);
			cmp_vld_s1 <= (state_q == S_SCAN);

			if (cmp_vld_s1) begin
				if (cmp.exact) begin
					exact_found_q <= 1'b1;
				end
				if (cmp.prefix) begin
					prefix_q <= 1'b1;
				end
				if (!valid_s1) begin
					free_found_q <= 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_KEY) begin
							pending_bytes_q <= new_bytes;
							pending_count_q <= new_cnt;
						end else begin
							pending_bytes_q <= '0;
							pending_count_q <= '0;
						end
						if (action == ACT_CLEAR) begin
							valid_q <= '0;
						end else begin
							state_q       <= S_SCAN;
							rd_addr_q     <= '0;
							exact_found_q <= 1'b0;
							prefix_q      <= 1'b0;
							free_found_q  <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
					if (rd_addr_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_IDLE;
					if (q_action_q == ACT_KEY && !keep_pending) begin
						pending_bytes_q <= '0;
						pending_count_q <= '0;
					end
					if (wr_en) begin
						valid_q[wr_idx] <= 1'b1;
					end
					if (clr_valid) begin
						valid_q[wr_idx] <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= rd_addr_q;
		valid_s1 <= valid_q[rd_addr_q];

		if (accept) begin
			q_action_q <= action;
			q_func_q   <= entry_function;
			if (action == ACT_KEY) begin
				q_keys_q <= new_bytes;
				q_len_q  <= new_cnt;
			end else begin
				q_keys_q <= eq_keys;
				q_len_q  <= eq_len;
			end
		end

		// hold the first hit and the first free slot of the scan
		if (cmp_vld_s1) begin
			if (cmp.exact && !exact_found_q) begin
				exact_idx_q  <= idx_s1;
				exact_func_q <= rd_entry.func;
			end
			if (!valid_s1 && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end

		if (state_q == S_FINISH) begin
			status_q <= fin_status;
			func_q   <= fin_func;
			len_q    <= q_len_q;
		end else if (accept && action == ACT_CLEAR) begin
			status_q <= ST_CLEARED;
			func_q   <= '0;
			len_q    <= '0;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign matched_function = func_q;
	assign sequence_length  = len_q;

endmodule

FILE: sv/ksm_checker.sv
// ----------------------------------------------------------------------------
// ksm_checker
// Port-level checks of the key sequence matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [ksm_pkg::ACT_W-1:0]    action,
	input logic                         done,
	input logic [ksm_pkg::ST_W-1:0]     status,
	input logic [ksm_pkg::FUNC_W-1:0]   matched_function,
	input logic [ksm_pkg::LEN_W-1:0]    sequence_length
);

	import ksm_pkg::*;

	// a scanning transaction locks the channel until its result
	`ASSERT_NEXT(a_scan_busy, start && !busy && action != ACT_CLEAR, busy && !done)

	// clear-all answers in the next cycle with an empty length
	`ASSERT_NEXT(a_clear_reply, start && !busy && action == ACT_CLEAR, done && status == ST_CLEARED && sequence_length == '0)

	// only a match carries a function number
	`ASSERT_SAME(a_func_zero, done && status != ST_MATCHED, matched_function == '0)

	// key results report a sequence of one to MAX_KEYS bytes
	`ASSERT_SAME(a_key_len, done && (status == ST_PENDING || status == ST_MATCHED || status == ST_UNKNOWN), sequence_length != '0 && sequence_length <= LEN_W'(MAX_KEYS))

endmodule

bind key_sequence_matcher ksm_checker u_ksm_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key sequence matcher. A directed table covers
// the field extremes, every action and the lookup corner cases. A random
// stream of keystrokes, binds, removes and clears follows, including a pass
// that fills the binding table past capacity. Each result is checked against
// a typed row or a behavioral copy of the binding table and pending sequence.
// ----------------------------------------------------------------------------
module tb;
	import ksm_pkg::*;

	localparam int RANDOM_ITEMS = 1290;
	localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [BYTE_W-1:0] kb;
		logic [KEY_W-1:0]  ekeys;
		logic [LEN_W-1:0]  elen;
		logic [FUNC_W-1:0] efn;
	} item_t;

	typedef struct packed {
		logic [ST_W-1:0]   st;
		logic [FUNC_W-1:0] fn;
		logic [LEN_W-1:0]  slen;
	} outcome_t;

	typedef struct packed {
		item_t    it;
		bit       typed;
		outcome_t want;
	} step_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [ACT_W-1:0]    action = '0;
	logic [BYTE_W-1:0]   key_byte = '0;
	logic [KEY_W-1:0]    entry_key_bytes = '0;
	logic [LEN_W-1:0]    entry_key_length = '0;
	logic [FUNC_W-1:0]   entry_function = '0;
	logic                done;
	logic [ST_W-1:0]     status;
	logic [FUNC_W-1:0]   matched_function;
	logic [LEN_W-1:0]    sequence_length;

	// shadow of the binding table and the pending keystroke sequence
	logic              tbl_valid [TABLE_ENTRIES];
	logic [LEN_W-1:0]  tbl_len   [TABLE_ENTRIES];
	logic [KEY_W-1:0]  tbl_keys  [TABLE_ENTRIES];
	logic [FUNC_W-1:0] tbl_func  [TABLE_ENTRIES];
	logic [KEY_W-1:0]  seq_bytes = '0;
	logic [LEN_W-1:0]  seq_count = '0;

	outcome_t          awaited_outcomes [$];
	logic [BYTE_W-1:0] keystroke_plan [$];
	step_row_t         opening_steps [$];
	int                fail_count = 0;
	bit                idle_on = 1'b1;

	key_sequence_matcher u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.key_byte         (key_byte),
		.entry_key_bytes  (entry_key_bytes),
		.entry_key_length (entry_key_length),
		.entry_function   (entry_function),
		.done             (done),
		.status           (status),
		.matched_function (matched_function),
		.sequence_length  (sequence_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_len[i]   = '0;
			tbl_keys[i]  = '0;
			tbl_func[i]  = '0;
		end
	end

	function automatic logic [KEY_W-1:0] low_bytes(logic [KEY_W-1:0] keys, logic [LEN_W-1:0] n);
		return (n >= LEN_W'(MAX_KEYS)) ? keys : keys & ((32'h1 << (8 * n)) - 32'h1);
	endfunction

	function automatic int find_binding(logic [KEY_W-1:0] keys, logic [LEN_W-1:0] len);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tbl_valid[i] && tbl_len[i] == len && tbl_keys[i] == keys) begin
				return i;
			end
		end
		return -1;
	endfunction

	// apply one accepted transaction to the shadow state and return its result
	function automatic outcome_t resolve_action(item_t it);
		outcome_t         o;
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] keys;
		int               hit;
		bit               prefix;
		len = (it.elen == '0) ? LEN_W'(1) :
			((it.elen > LEN_W'(MAX_KEYS)) ? LEN_W'(MAX_KEYS) : it.elen);
		keys = low_bytes(it.ekeys, len);
		o.st = ST_CLEARED;
		o.fn = '0;
		o.slen = len;
		if (it.act == ACT_KEY) begin
			if (seq_count >= LEN_W'(MAX_KEYS)) begin
				seq_bytes = '0;
				seq_count = '0;
			end
			seq_bytes = seq_bytes | (KEY_W'(it.kb) << (8 * seq_count));
			seq_count = seq_count + LEN_W'(1);
			o.slen = seq_count;
			hit = find_binding(seq_bytes, seq_count);
			if (hit >= 0) begin
				o.st = ST_MATCHED;
				o.fn = tbl_func[hit];
			end else begin
				prefix = 1'b0;
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (tbl_valid[i] && tbl_len[i] > seq_count &&
							low_bytes(tbl_keys[i], seq_count) == seq_bytes) begin
						prefix = 1'b1;
					end
				end
				o.st = prefix ? ST_PENDING : ST_UNKNOWN;
			end
			if (o.st != ST_PENDING) begin
				seq_bytes = '0;
				seq_count = '0;
			end
			return o;
		end
		// any table edit drops the pending sequence
		seq_bytes = '0;
		seq_count = '0;
		hit = find_binding(keys, len);
		case (it.act)
			ACT_BIND: begin
				if (int'(it.efn) >= FUNCTION_COUNT) begin
					o.st = ST_NOTFOUND;
				end else begin
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						if (hit < 0 && !tbl_valid[i]) begin
							hit = i;
						end
					end
					if (hit < 0) begin
						o.st = ST_FULL;
					end else begin
						tbl_valid[hit] = 1'b1;
						tbl_len[hit]   = len;
						tbl_keys[hit]  = keys;
						tbl_func[hit]  = it.efn;
						o.st = ST_BOUND;
					end
				end
			end
			ACT_REMOVE: begin
				if (hit < 0) begin
					o.st = ST_NOTFOUND;
				end else begin
					tbl_valid[hit] = 1'b0;
					o.st = ST_REMOVED;
				end
			end
			default: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					tbl_valid[i] = 1'b0;
				end
				o.st = ST_CLEARED;
				o.slen = '0;
			end
		endcase
		return o;
	endfunction

	function automatic step_row_t mk_row(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] kb,
			logic [KEY_W-1:0] ekeys, logic [LEN_W-1:0] elen, logic [FUNC_W-1:0] efn,
			bit typed, logic [ST_W-1:0] st, logic [FUNC_W-1:0] fn, logic [LEN_W-1:0] slen);
		step_row_t r;
		r.it = '{act, kb, ekeys, elen, efn};
		r.typed = typed;
		r.want = '{st, fn, slen};
		return r;
	endfunction

	// mostly a narrow alphabet so that keys share prefixes
	function automatic logic [BYTE_W-1:0] pick_byte();
		if ($urandom_range(0, 4) == 0) begin
			return BYTE_W'($urandom);
		end
		return 8'h61 + BYTE_W'($urandom_range(0, 3));
	endfunction

	function automatic int pick_live_slot();
		int live [$];
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				live.push_back(i);
			end
		end
		if (live.size() == 0) begin
			return -1;
		end
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	// type a bound key in full, or part of it and then a stray byte, or random bytes
	function automatic void plan_keystrokes();
		int e;
		int stop;
		e = pick_live_slot();
		if (e < 0 || $urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 4)) keystroke_plan.push_back(pick_byte());
		end else begin
			stop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, int'(tbl_len[e]) - 1) :
				int'(tbl_len[e]);
			for (int b = 0; b < stop; b++) begin
				keystroke_plan.push_back(tbl_keys[e][8*b +: 8]);
			end
			if (stop < int'(tbl_len[e])) begin
				keystroke_plan.push_back(pick_byte());
			end
		end
	endfunction

	function automatic item_t random_item();
		item_t it;
		int    r;
		int    e;
		it.act   = ACT_KEY;
		it.kb    = BYTE_W'($urandom);
		it.ekeys = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		it.elen  = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 7)) :
			LEN_W'($urandom_range(1, 4));
		it.efn   = FUNC_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 60) begin
			if (keystroke_plan.size() == 0) begin
				plan_keystrokes();
			end
			it.kb = keystroke_plan.pop_front();
		end else if (r < 80) begin
			it.act = ACT_BIND;
		end else if (r < 97) begin
			it.act = ACT_REMOVE;
			e = pick_live_slot();
			if (e >= 0 && $urandom_range(0, 9) < 7) begin
				// hit a bound key; junk above its length must not matter
				it.ekeys = tbl_keys[e] | (KEY_W'($urandom) & ~low_bytes('1, tbl_len[e]));
				it.elen = tbl_len[e];
				if (tbl_len[e] == LEN_W'(MAX_KEYS) && $urandom_range(0, 1) == 0) begin
					it.elen = LEN_W'($urandom_range(MAX_KEYS, 7));
				end
				if (tbl_len[e] == LEN_W'(1) && $urandom_range(0, 1) == 0) begin
					it.elen = '0;
				end
			end else if ($urandom_range(0, 1) == 0) begin
				it.ekeys = KEY_W'($urandom);
			end
		end else begin
			it.act = ACT_CLEAR;
		end
		return it;
	endfunction

	// present one transaction, idle at random while it waits, record its result
	task automatic issue_action(input item_t it, input bit use_typed, input outcome_t typed_out);
		outcome_t predicted;
		action           <= it.act;
		key_byte         <= it.kb;
		entry_key_bytes  <= it.ekeys;
		entry_key_length <= it.elen;
		entry_function   <= it.efn;
		start            <= 1'b1;
		forever begin
			@(negedge clk);
			if (!busy) begin
				break;
			end
			if (idle_on && $urandom_range(0, 24) == 0) begin
				@(posedge clk);
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				start <= 1'b1;
			end
		end
		@(posedge clk);
		predicted = resolve_action(it);
		awaited_outcomes.push_back(use_typed ? typed_out : predicted);
	endtask

	always @(negedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_outcomes.size() == 0) begin
				$error("unexpected result: status %0d function %0d length %0d",
					status, matched_function, sequence_length);
				fail_count++;
			end else begin
				want = awaited_outcomes.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_count++;
				end
				if (matched_function !== want.fn) begin
					$error("matched_function: expected %0d, got %0d", want.fn,
						matched_function);
					fail_count++;
				end
				if (sequence_length !== want.slen) begin
					$error("sequence_length: expected %0d, got %0d", want.slen,
						sequence_length);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		item_t it;
		int    k;
		opening_steps = '{
			mk_row(ACT_KEY,    8'h00, 32'h0000_0000, 3'd1, 7'd0,   1'b1, ST_UNKNOWN,  7'd0, 3'd1),
			mk_row(ACT_KEY,    8'hFF, 32'hFFFF_FFFF, 3'd7, 7'd127, 1'b1, ST_UNKNOWN,  7'd0, 3'd1),
			mk_row(ACT_REMOVE, 8'h00, 32'hFFFF_FFFF, 3'd4, 7'd0,   1'b1, ST_NOTFOUND, 7'd0, 3'd4),
			mk_row(ACT_BIND,   8'h00, 32'h0000_0041, 3'd0, 7'd127, 1'b1, ST_BOUND,    7'd0, 3'd1),
			mk_row(ACT_BIND,   8'h00, 32'h4443_4241, 3'd4, 7'd0,   1'b1, ST_BOUND,    7'd0, 3'd4),
			mk_row(ACT_BIND,   8'h00, 32'hFFFF_4241, 3'd2, 7'd5,   1'b1, ST_BOUND,    7'd0, 3'd2),
			// exact one-byte entry beats the longer ones it prefixes
			mk_row(ACT_KEY,    8'h41, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_REMOVE, 8'h00, 32'h1234_5641, 3'd0, 7'd0,   1'b1, ST_REMOVED,  7'd0, 3'd1),
			mk_row(ACT_KEY,    8'h41, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h42, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h41, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			// edit while a sequence is pending; oversize length folds to four
			mk_row(ACT_BIND,   8'h00, 32'h0000_0042, 3'd7, 7'd64,  1'b1, ST_BOUND,    7'd0, 3'd4),
			mk_row(ACT_KEY,    8'h42, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h00, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h00, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h00, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_BIND,   8'h00, 32'h0000_0042, 3'd5, 7'd33,  1'b1, ST_BOUND,    7'd0, 3'd4),
			mk_row(ACT_REMOVE, 8'h00, 32'h0000_4241, 3'd2, 7'd0,   1'b1, ST_REMOVED,  7'd0, 3'd2),
			mk_row(ACT_KEY,    8'h41, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h42, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h43, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h45, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h41, 32'h0000_0000, 3'd0, 7'd0,   1'b0, ST_PENDING,  7'd0, 3'd0),
			mk_row(ACT_CLEAR,  8'h41, 32'hA5A5_5A5A, 3'd6, 7'd99,  1'b1, ST_CLEARED,  7'd0, 3'd0),
			mk_row(ACT_KEY,    8'h41, 32'h0000_0000, 3'd0, 7'd0,   1'b1, ST_UNKNOWN,  7'd0, 3'd1)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_steps[i]) begin
			issue_action(opening_steps[i].it, opening_steps[i].typed, opening_steps[i].want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				idle_on = (n < RANDOM_ITEMS - 200) && ($urandom_range(0, 3) != 0);
			end
			if (n == RANDOM_ITEMS / 2) begin
				// fill every slot with distinct first bytes, then push past capacity
				it = random_item();
				it.act = ACT_CLEAR;
				issue_action(it, 1'b0, '0);
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					it = random_item();
					it.act = ACT_BIND;
					it.ekeys = {KEY_W'($urandom)} & ~KEY_W'(8'hFF) | KEY_W'(i);
					issue_action(it, 1'b0, '0);
				end
				repeat (2) begin
					it = random_item();
					it.act = ACT_BIND;
					it.ekeys[7] = 1'b1;
					issue_action(it, 1'b0, '0);
				end
				// overwrite still works on a full table
				k = $urandom_range(0, TABLE_ENTRIES - 1);
				it = random_item();
				it.act = ACT_BIND;
				it.ekeys = tbl_keys[k];
				it.elen = tbl_len[k];
				issue_action(it, 1'b0, '0);
			end
			it = random_item();
			issue_action(it, 1'b0, '0);
		end

		start <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
